// File: rtl/core/ccs_pkg.sv
// Package for the C comment stripper: scan mode codes, character codes
// and the result and scan-output structs. No dependencies.
package ccs_pkg;

    typedef enum logic [2:0] {
        MODE_NORMAL     = 3'd0,
        MODE_SLASH      = 3'd1,
        MODE_BLOCK      = 3'd2,
        MODE_BLOCK_STAR = 3'd3,
        MODE_LINE       = 3'd4,
        MODE_LIT        = 3'd5,
        MODE_LIT_ESC    = 3'd6
    } scan_mode_t;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;

    // Result queue: four entries, two address bits, count holds 0..4.
    localparam int unsigned RES_DEPTH = 4;
    localparam int unsigned RES_PTR_W = 2;
    localparam int unsigned RES_CNT_W = 3;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       out_last;
    } res_t;

    typedef struct packed {
        res_t       res0;
        res_t       res1;
        logic [1:0] num;
    } scan_out_t;

endpackage

// File: rtl/core/ccs_scan.sv
// Scanner: holds the comment/literal scan state and turns one accepted
// input item into up to two result items. Depends on ccs_pkg.
module ccs_scan
    import ccs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output scan_out_t  scan
);

    scan_mode_t mode_reg, mode_next;
    logic       dquote_reg, dquote_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_NORMAL;
            dquote_reg <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg   <= mode_next;
            dquote_reg <= dquote_next;
        end
    end

    always_comb
    begin
        scan_mode_t m;
        logic       dq;
        logic [7:0] q;
        res_t       r0;
        res_t       r1;
        logic [1:0] n;
        logic       pass_normal;
        logic       pass_emit;

        m           = mode_reg;
        dq          = dquote_reg;
        q           = dquote_reg ? CH_DQUOTE : CH_SQUOTE;
        r0          = '0;
        r1          = '0;
        n           = 2'd0;
        pass_normal = 1'b0;
        pass_emit   = 1'b0;

        case (mode_reg)
            MODE_SLASH:
            begin
                if (in_byte == CH_STAR)
                    m = MODE_BLOCK;
                else if (in_byte == CH_SLASH)
                    m = MODE_LINE;
                else
                begin
                    // release the held slash, then treat the byte as plain text
                    r0          = '{out_byte: CH_SLASH, has_byte: 1'b1, out_last: 1'b0};
                    n           = 2'd1;
                    pass_normal = 1'b1;
                end
            end
            MODE_BLOCK:
                m = (in_byte == CH_STAR) ? MODE_BLOCK_STAR : MODE_BLOCK;
            MODE_BLOCK_STAR:
            begin
                if (in_byte == CH_SLASH)
                    m = MODE_NORMAL;
                else
                    m = (in_byte == CH_STAR) ? MODE_BLOCK_STAR : MODE_BLOCK;
            end
            MODE_LINE:
            begin
                if (in_byte inside {CH_LF, CH_CR})
                    m = MODE_NORMAL;
            end
            MODE_LIT:
            begin
                pass_emit = 1'b1;
                if (in_byte == CH_BSLASH)
                    m = MODE_LIT_ESC;
                else if (in_byte == q)
                    m = MODE_NORMAL;
            end
            MODE_LIT_ESC:
            begin
                pass_emit = 1'b1;
                m         = MODE_LIT;
            end
            default:
                pass_normal = 1'b1;
        endcase

        if (pass_normal)
        begin
            if (in_byte == CH_SLASH)
                m = MODE_SLASH;
            else
            begin
                pass_emit = 1'b1;
                if (in_byte inside {CH_DQUOTE, CH_SQUOTE})
                begin
                    m  = MODE_LIT;
                    dq = (in_byte == CH_DQUOTE);
                end
                else
                    m = MODE_NORMAL;
            end
        end

        if (pass_emit)
        begin
            if (n == 2'd0)
                r0 = '{out_byte: in_byte, has_byte: 1'b1, out_last: 1'b0};
            else
                r1 = '{out_byte: in_byte, has_byte: 1'b1, out_last: 1'b0};
            n = n + 2'd1;
        end

        if (in_last)
        begin
            // flush a held slash, mark the final result, restart the text
            if (m == MODE_SLASH)
            begin
                if (n == 2'd0)
                    r0 = '{out_byte: CH_SLASH, has_byte: 1'b1, out_last: 1'b0};
                else
                    r1 = '{out_byte: CH_SLASH, has_byte: 1'b1, out_last: 1'b0};
                n = n + 2'd1;
            end
            if (n == 2'd0)
            begin
                r0 = '{out_byte: 8'h00, has_byte: 1'b0, out_last: 1'b0};
                n  = 2'd1;
            end
            if (n == 2'd2)
                r1.out_last = 1'b1;
            else
                r0.out_last = 1'b1;
            m  = MODE_NORMAL;
            dq = 1'b0;
        end

        mode_next   = m;
        dquote_next = dq;
        scan        = '{res0: r0, res1: r1, num: n};
    end

endmodule

// File: rtl/core/ccs_result_fifo.sv
// Four-entry result queue: takes up to two result items per cycle and
// hands out one per output handshake. Depends on ccs_pkg.
module ccs_result_fifo
    import ccs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  scan_out_t scan,
    output logic      room2,
    output logic      out_valid,
    input  logic      out_ready,
    output res_t      head
);

    res_t                 mem [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RES_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RES_CNT_W-1:0] count_reg, count_next;
    logic [1:0]           push_n;
    logic                 pop;

    assign push_n    = push ? scan.num : 2'd0;
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign head      = mem[rd_ptr_reg];
    // two free slots cover the worst case of one item
    assign room2     = (count_reg <= RES_CNT_W'(RES_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + RES_PTR_W'(push_n);
        rd_ptr_next = rd_ptr_reg + RES_PTR_W'(pop);
        count_next  = count_reg + RES_CNT_W'(push_n) - RES_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            mem[wr_ptr_reg] <= scan.res0;
        if (push_n == 2'd2)
            mem[wr_ptr_reg + RES_PTR_W'(1)] <= scan.res1;
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= RES_CNT_W'(RES_DEPTH))
        else $error("result queue count overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        push_n != 2'd0 |-> count_reg <= RES_CNT_W'(RES_DEPTH - 2))
        else $error("item taken without room for its results");

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> scan.num != 2'd3)
        else $error("result count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && push_n == 2'd0) |=> count_reg == $past(count_reg) - RES_CNT_W'(1))
        else $error("queue count did not drop on pop");
`endif

endmodule

// File: rtl/core/c_comment_stripper.sv
// C comment stripper top level: scanner plus result queue.
// Depends on ccs_pkg, ccs_scan and ccs_result_fifo.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------
//  input   | in_valid / in_ready  | in_byte[7:0], in_last
//  output  | out_valid / out_ready| out_byte[7:0], has_byte, out_last
//
// One input item per cycle while in_ready is high; an item gives zero, one or
// two results, and each result is registered in the result queue before it leaves.
// The output side moves one result per cycle while out_ready is high, so a held
// slash released alongside a byte takes an extra output handshake.
// in_ready is high while the four-entry result queue has two free slots.
// Reset clears the scan state and empties the queue.
module c_comment_stripper
    import ccs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       has_byte,
    output logic       out_last
);

    scan_out_t scan;
    res_t      head;
    logic      fire;

    assign fire = in_valid && in_ready;

    ccs_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .in_byte (in_byte),
        .in_last (in_last),
        .scan    (scan)
    );

    ccs_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .scan      (scan),
        .room2     (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign out_byte = head.out_byte;
    assign has_byte = head.has_byte;
    assign out_last = head.out_last;

endmodule

// File: sim/c_comment_stripper_tb.sv
`timescale 1ns / 100ps
// Testbench for c_comment_stripper: streams short texts through the block,
// predicts the comment-free output and checks every result. Uses ccs_pkg.
module c_comment_stripper_tb;
    import ccs_pkg::*;

    localparam int WATCHDOG_CYCLES = 1000;
    localparam int RANDOM_CHARS    = 950;
    localparam int DRAIN_CYCLES    = 20;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       in_last;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       out_last;

    text_char_t pending_chars [$];
    logic [7:0] text_buf [$];
    res_t       stripped_q [$];

    scan_mode_t strip_mode;
    logic       in_string;

    text_char_t next_char;
    res_t       got_res;
    res_t       want_res;
    logic       in_fire;
    int         chars_total;
    int         chars_taken;
    int         err_cnt;
    int         idle_cycles;
    int         src_gap;
    int         snk_gap;
    bit         src_calm;
    bit         snk_calm;

    c_comment_stripper i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .has_byte  (has_byte),
        .out_last  (out_last)
    );

    always #6 clk = ~clk;

    function automatic res_t text_res(input logic [7:0] b);
        res_t r;
        r.out_byte = b;
        r.has_byte = 1'b1;
        r.out_last = 1'b0;
        return r;
    endfunction

    // Work out the results one accepted character gives and queue them.
    task automatic predict_char(input logic [7:0] b, input logic last);
        res_t       step_res [2];
        int         n;
        logic [7:0] quote;
        logic       as_text;
        n = 0;
        as_text = 1'b0;
        quote = in_string ? CH_DQUOTE : CH_SQUOTE;
        case (strip_mode)
            MODE_SLASH:
            begin
                if (b == CH_STAR)
                    strip_mode = MODE_BLOCK;
                else if (b == CH_SLASH)
                    strip_mode = MODE_LINE;
                else
                begin
                    // release the held slash, then treat b as plain text
                    step_res[n] = text_res(CH_SLASH);
                    n++;
                    as_text = 1'b1;
                end
            end
            MODE_BLOCK:
            begin
                if (b == CH_STAR)
                    strip_mode = MODE_BLOCK_STAR;
            end
            MODE_BLOCK_STAR:
            begin
                if (b == CH_SLASH)
                    strip_mode = MODE_NORMAL;
                else if (b != CH_STAR)
                    strip_mode = MODE_BLOCK;
            end
            MODE_LINE:
            begin
                if (b == CH_LF || b == CH_CR)
                    strip_mode = MODE_NORMAL;
            end
            MODE_LIT:
            begin
                step_res[n] = text_res(b);
                n++;
                if (b == CH_BSLASH)
                    strip_mode = MODE_LIT_ESC;
                else if (b == quote)
                    strip_mode = MODE_NORMAL;
            end
            MODE_LIT_ESC:
            begin
                step_res[n] = text_res(b);
                n++;
                strip_mode = MODE_LIT;
            end
            default:
                as_text = 1'b1;
        endcase
        if (as_text)
        begin
            if (b == CH_SLASH)
                strip_mode = MODE_SLASH;
            else
            begin
                if (b == CH_DQUOTE || b == CH_SQUOTE)
                begin
                    strip_mode = MODE_LIT;
                    in_string = (b == CH_DQUOTE);
                end
                else
                    strip_mode = MODE_NORMAL;
                step_res[n] = text_res(b);
                n++;
            end
        end
        if (last)
        begin
            if (strip_mode == MODE_SLASH)
            begin
                step_res[n] = text_res(CH_SLASH);
                n++;
            end
            if (n == 0)
            begin
                step_res[0] = '0;
                n = 1;
            end
            step_res[n-1].out_last = 1'b1;
            strip_mode = MODE_NORMAL;
            in_string = 1'b0;
        end
        for (int i = 0; i < n; i++)
            stripped_q = {stripped_q, step_res[i]};
    endtask

    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic logic [7:0] special_char();
        case ($urandom_range(0, 6))
            0: return CH_STAR;
            1: return CH_SLASH;
            2: return CH_LF;
            3: return CH_CR;
            4: return CH_BSLASH;
            5: return CH_DQUOTE;
            default: return CH_SQUOTE;
        endcase
    endfunction

    function automatic logic [7:0] fill_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 8'($urandom_range(8'h61, 8'h7A));
        if (r < 8)
            return special_char();
        return 8'($urandom_range(0, 255));
    endfunction

    // Move the text buffer into the pending items, marking its final char.
    task automatic flush_text();
        text_char_t c;
        for (int i = 0; i < text_buf.size(); i++)
        begin
            c.ch = text_buf[i];
            c.last = (i == text_buf.size() - 1);
            pending_chars = {pending_chars, c};
        end
        chars_total += text_buf.size();
        text_buf.delete();
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf = {text_buf, s[i]};
        flush_text();
    endtask

    // Append one piece: text, or a mostly well-formed comment or literal.
    task automatic add_token();
        int         r;
        int         k;
        logic [7:0] quote;
        r = $urandom_range(0, 99);
        if (r < 35)
            text_buf = {text_buf, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                              : 8'($urandom_range(8'h61, 8'h7A))};
        else if (r < 47)
            text_buf = {text_buf, special_char()};
        else if (r < 60)
        begin
            text_buf = {text_buf, CH_SLASH};
            text_buf = {text_buf, CH_STAR};
            k = $urandom_range(0, 8);
            repeat (k) text_buf = {text_buf, fill_char()};
            if ($urandom_range(0, 9) != 0)
            begin
                text_buf = {text_buf, CH_STAR};
                text_buf = {text_buf, CH_SLASH};
            end
        end
        else if (r < 72)
        begin
            text_buf = {text_buf, CH_SLASH};
            text_buf = {text_buf, CH_SLASH};
            k = $urandom_range(0, 8);
            repeat (k) text_buf = {text_buf, fill_char()};
            if ($urandom_range(0, 9) != 0)
                text_buf = {text_buf, $urandom_range(0, 1) ? CH_LF : CH_CR};
        end
        else if (r < 90)
        begin
            quote = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
            text_buf = {text_buf, quote};
            k = $urandom_range(0, 8);
            repeat (k)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    text_buf = {text_buf, CH_BSLASH};
                    text_buf = {text_buf, $urandom_range(0, 1) ? quote : fill_char()};
                end
                else
                    text_buf = {text_buf, fill_char()};
            end
            if ($urandom_range(0, 9) != 0)
                text_buf = {text_buf, quote};
        end
        else
        begin
            text_buf = {text_buf, CH_SLASH};
            text_buf = {text_buf, fill_char()};
        end
    endtask

    initial
    begin
        int target_len;
        int random_start;
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_byte = '0;
        in_last = 1'b0;
        out_ready = 1'b0;
        in_fire = 1'b0;
        strip_mode = MODE_NORMAL;
        in_string = 1'b0;
        chars_total = 0;
        chars_taken = 0;
        err_cnt = 0;
        idle_cycles = 0;
        src_gap = 0;
        snk_gap = 0;
        src_calm = 1'b0;
        snk_calm = 1'b0;

        // opening star must not close the comment
        push_str("/*/*/");
        push_str("//c\nz");
        push_str("'\\''");
        push_str("\"/*\"");
        // slash still held at end of text
        push_str("a/");
        // unterminated comment leaves only the end marker
        push_str("/*");
        text_buf = {text_buf, 8'hFF};
        flush_text();
        text_buf = {text_buf, 8'h00};
        flush_text();

        random_start = chars_total;
        while (chars_total - random_start < RANDOM_CHARS)
        begin
            target_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(1, 25);
            while (text_buf.size() < target_len)
                add_token();
            flush_text();
        end

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        while (chars_taken < chars_total || stripped_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Source side: hold each item until taken, then advance after a gap.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_fire)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_chars.size() > 0)
                begin
                    next_char = pending_chars.pop_front();
                    in_valid <= 1'b1;
                    in_byte <= next_char.ch;
                    in_last <= next_char.last;
                    if ($urandom_range(0, 63) == 0)
                        src_calm = !src_calm;
                    src_gap = pick_gap(src_calm);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Sink side: drop ready for random stretches.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (snk_gap > 0)
            begin
                snk_gap--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 63) == 0)
                    snk_calm = !snk_calm;
                if ($urandom_range(0, 3) == 0)
                    snk_gap = pick_gap(snk_calm);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_fire <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                predict_char(in_byte, in_last);
                chars_taken++;
            end
            if (out_valid && out_ready)
            begin
                got_res.out_byte = out_byte;
                got_res.has_byte = has_byte;
                got_res.out_last = out_last;
                if (stripped_q.size() == 0)
                begin
                    if (err_cnt < 10)
                        $display("unexpected result: byte %02h has %0b last %0b",
                                 got_res.out_byte, got_res.has_byte, got_res.out_last);
                    err_cnt++;
                end
                else
                begin
                    want_res = stripped_q.pop_front();
                    if (got_res.out_byte != want_res.out_byte
                        || got_res.has_byte != want_res.has_byte
                        || got_res.out_last != want_res.out_last)
                    begin
                        if (err_cnt < 10)
                            $display("mismatch: want %02h/%0b/%0b got %02h/%0b/%0b",
                                     want_res.out_byte, want_res.has_byte, want_res.out_last,
                                     got_res.out_byte, got_res.has_byte, got_res.out_last);
                        err_cnt++;
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles == WATCHDOG_CYCLES)
                begin
                    $display("end of test: mismatches");
                    $finish;
                end
            end
        end
    end

endmodule

// File: c_comment_stripper.f
rtl/core/ccs_pkg.sv
rtl/core/ccs_scan.sv
rtl/core/ccs_result_fifo.sv
rtl/core/c_comment_stripper.sv
sim/c_comment_stripper_tb.sv
